FILE: rtl/core/hstmc_pkg.sv
// Shared types and codes for the hard-sphere trial move checker.
// No dependencies; all other files but the checker use this package by scoped names.
package hstmc_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TRIAL = 1'b1;

  localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
  localparam logic [1:0] CFG_BOX_LENGTH = 2'd1;
  localparam logic [1:0] CFG_INV_BOX    = 2'd2;
  localparam logic [1:0] CFG_CONTACT_SQ = 2'd3;

  localparam logic [10:0] ATOM_COUNT_RST = 11'd1;
  localparam logic [30:0] BOX_LENGTH_RST = 31'd65536;
  localparam logic [31:0] INV_BOX_RST    = 32'd65536;
  localparam logic [62:0] CONTACT_SQ_RST = 63'h0000_0001_0000_0000;

  // Register stages from memory read data to the squared wrapped distance.
  localparam int AXIS_LAT = 6;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  typedef struct packed {
    logic [31:0] inv_box;
    logic [30:0] box;
  } wrap_cfg_t;

endpackage

FILE: rtl/core/hard_sphere_trial_move_check.sv
// Hard-sphere trial move checker, top level. Uses hstmc_pkg, hstmc_pos_mem, hstmc_axis_pipe.
// A trial sweeps the first min(atom_count, ATOM_SLOTS) stored positions, reading one stored
// position per cycle through the single read port into the 9-stage distance pipeline.
// A load, or a trial whose index lies beyond the table, skips the sweep.
// One item is in work at a time; the input is ready for the next beat in the same cycle as a result appears.
// Reset restores the configuration defaults; the position table is not cleared.
module hard_sphere_trial_move_check #(
  parameter int ATOM_SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [62:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [9:0]         in_atom_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic [9:0]         out_echo_index
);

  localparam int AW       = $clog2(ATOM_SLOTS);
  localparam int LW       = ($clog2(ATOM_SLOTS + 1) > 11) ? $clog2(ATOM_SLOTS + 1) : 11;
  localparam int IW       = (AW > 10) ? AW : 10;
  localparam int PIPE_LEN = hstmc_pkg::AXIS_LAT + 3;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_FINISH} state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return s[64] ? '1 : s[63:0];
  endfunction

  state_t            state_r;
  logic [10:0]       atom_count_r;
  logic [30:0]       box_length_r;
  logic [31:0]       inv_box_r;
  logic [62:0]       contact_sq_r;
  logic [9:0]        idx_r;
  hstmc_pkg::pos_t   trial_r;
  logic              ok_r;
  logic [LW-1:0]     cnt_r;
  logic              out_valid_r;
  logic              out_accepted_r;
  logic [9:0]        out_echo_r;
  logic [PIPE_LEN-1:0] pv_r;
  logic [PIPE_LEN-1:0] ps_r;
  logic [63:0]       sxy_r, sz_r, r_r;

  logic [LW-1:0]     count_ext;
  logic [LW-1:0]     lim;
  logic              in_range;
  logic              issue;
  logic              is_self;
  logic              out_free;
  logic              wr_en;
  logic [IW-1:0]     idx_ext;
  logic [LW:0]       cnt_inc;
  hstmc_pkg::pos_t   rd_data;
  hstmc_pkg::pos_t   wr_data;
  hstmc_pkg::wrap_cfg_t wcfg;
  logic [63:0]       sq_x, sq_y, sq_z;

  assign count_ext = LW'(atom_count_r);
  assign lim       = (count_ext < LW'(ATOM_SLOTS)) ? count_ext : LW'(ATOM_SLOTS);
  assign in_range  = 32'(in_atom_index) < 32'(ATOM_SLOTS);
  assign issue     = (state_r == ST_SWEEP) && (cnt_r < lim);
  assign is_self   = 32'(cnt_r) == 32'(idx_r);
  assign out_free  = !out_valid_r || out_ready;
  assign wr_en     = (state_r == ST_FINISH) && out_free && ok_r;
  assign idx_ext   = IW'(idx_r);
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign wr_data   = trial_r;
  assign wcfg      = '{inv_box: inv_box_r, box: box_length_r};

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_echo_index = out_echo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= hstmc_pkg::ATOM_COUNT_RST;
      box_length_r <= hstmc_pkg::BOX_LENGTH_RST;
      inv_box_r    <= hstmc_pkg::INV_BOX_RST;
      contact_sq_r <= hstmc_pkg::CONTACT_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hstmc_pkg::CFG_ATOM_COUNT: atom_count_r <= cfg_data[10:0];
        hstmc_pkg::CFG_BOX_LENGTH: box_length_r <= cfg_data[30:0];
        hstmc_pkg::CFG_INV_BOX:    inv_box_r    <= cfg_data[31:0];
        hstmc_pkg::CFG_CONTACT_SQ: contact_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            idx_r     <= in_atom_index;
            trial_r   <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
            ok_r      <= in_range;
            cnt_r     <= '0;
            state_r   <= (in_kind == hstmc_pkg::KIND_TRIAL && in_range) ? ST_SWEEP : ST_FINISH;
          end
        end
        ST_SWEEP: begin
          cnt_r <= cnt_inc[LW-1:0];
          if (!(cnt_inc < {1'b0, lim})) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pv_r == '0) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_accepted_r <= ok_r;
            out_echo_r     <= idx_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (pv_r[PIPE_LEN-1] && !ps_r[PIPE_LEN-1] && (r_r < 64'(contact_sq_r))) begin
        ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[PIPE_LEN-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    ps_r  <= {ps_r[PIPE_LEN-2:0], is_self};
    sxy_r <= sat_add(sq_x, sq_y);
    sz_r  <= sq_z;
    r_r   <= sat_add(sxy_r, sz_r);
  end

  hstmc_pos_mem #(
    .DEPTH (ATOM_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (cnt_r[AW-1:0]),
    .rd_data (rd_data)
  );

  hstmc_axis_pipe u_axis_x (
    .clk   (clk),
    .other (rd_data.x),
    .trial (trial_r.x),
    .wcfg  (wcfg),
    .sq    (sq_x)
  );

  hstmc_axis_pipe u_axis_y (
    .clk   (clk),
    .other (rd_data.y),
    .trial (trial_r.y),
    .wcfg  (wcfg),
    .sq    (sq_y)
  );

  hstmc_axis_pipe u_axis_z (
    .clk   (clk),
    .other (rd_data.z),
    .trial (trial_r.z),
    .wcfg  (wcfg),
    .sq    (sq_z)
  );

endmodule

FILE: rtl/core/hstmc_pos_mem.sv
// Position table: one write port and one read port with registered read data.
// Depends on hstmc_pkg for the position type.
module hstmc_pos_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  hstmc_pkg::pos_t     wr_data,
  input  logic [AW-1:0]       rd_addr,
  output hstmc_pkg::pos_t     rd_data
);

  hstmc_pkg::pos_t mem [DEPTH];
  hstmc_pkg::pos_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/hstmc_axis_pipe.sv
// One axis of the minimum-image distance: difference, rounded wrap count,
// wrap and square, in six register stages. Depends on hstmc_pkg.
module hstmc_axis_pipe (
  input  logic                  clk,
  input  logic signed [31:0]    other,
  input  logic signed [31:0]    trial,
  input  hstmc_pkg::wrap_cfg_t  wcfg,
  output logic [63:0]           sq
);

  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic signed [32:0] d1_r, d2_r, d3_r, d4_r;
  logic [31:0]        mag1_r;
  logic [63:0]        p2_r;
  logic [63:0]        round_sum;
  logic [31:0]        n3_r;
  logic [62:0]        term4_r;
  logic signed [64:0] d_ext;
  logic signed [64:0] term_ext;
  logic signed [64:0] w;
  logic [64:0]        wm;
  logic               sat5_r;
  logic [31:0]        wm5_r;
  logic [63:0]        sq6_r;

  assign diff      = 33'(other) - 33'(trial);
  assign diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
  assign round_sum = p2_r + 64'h0000_0000_8000_0000;
  assign d_ext     = 65'(d4_r);
  assign term_ext  = $signed({2'b00, term4_r});
  assign w         = d4_r[32] ? d_ext + term_ext : d_ext - term_ext;
  assign wm        = w[64] ? 65'(-w) : 65'(w);

  always_ff @(posedge clk) begin
    d1_r    <= diff;
    mag1_r  <= diff_mag[31:0];
    d2_r    <= d1_r;
    p2_r    <= 64'(mag1_r) * 64'(wcfg.inv_box);
    d3_r    <= d2_r;
    n3_r    <= round_sum[63:32];
    d4_r    <= d3_r;
    term4_r <= 63'(n3_r) * 63'(wcfg.box);
    sat5_r  <= |wm[64:32];
    wm5_r   <= wm[31:0];
    sq6_r   <= sat5_r ? '1 : 64'(wm5_r) * 64'(wm5_r);
  end

  assign sq = sq6_r;

endmodule

FILE: rtl/core/hstmc_checker.sv
// Port-level checks for the hard-sphere trial move checker, bound to the top level.
// Depends only on the top level's ports.
module hstmc_checker #(
  parameter int ATOM_SLOTS = 1024
) (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [62:0]        cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_kind,
  input logic [9:0]         in_atom_index,
  input logic signed [31:0] in_pos_x,
  input logic signed [31:0] in_pos_y,
  input logic signed [31:0] in_pos_z,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_accepted,
  input logic [9:0]         out_echo_index
);

  // An accepted beat leaves the input side busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an accepted beat");

  // A new result only appears after the block was busy.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  // Returning to ready always coincides with a result on the output.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid)
    else $error("input ready returned without a result");

  // An index outside the table is never reported as accepted.
  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (32'(out_echo_index) >= 32'(ATOM_SLOTS)) |-> !out_accepted)
    else $error("index beyond the table reported as accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_echo_index))
    else $error("stalled result beat changed");

endmodule

bind hard_sphere_trial_move_check hstmc_checker #(.ATOM_SLOTS(ATOM_SLOTS)) u_hstmc_checker (.*);

FILE: bench/tb.sv
// Testbench for hard_sphere_trial_move_check: a directed table of beats and register writes,
// then random settings, loads and trials; an overlap predictor checks all but typed beats.
// Depends on hstmc_pkg and the RTL of the block, nothing else.
module tb;

  localparam int SLOTS = 1024;
  localparam int UNIT = 65536;
  localparam int RANDOM_BEATS = 540;
  localparam int LIMIT = 2_000_000;

  typedef enum bit {ROW_CFG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t       what;
    logic [1:0]      which;
    longint unsigned value;
    logic            kind;
    logic [9:0]      idx;
    int              px;
    int              py;
    int              pz;
    bit              typed;
    bit              want;
  } script_row_t;

  typedef struct {
    logic       accepted;
    logic [9:0] echo;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [62:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_kind = 1'b0;
  logic [9:0]         in_atom_index = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_pos_z = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               out_accepted;
  logic [9:0]         out_echo_index;

  longint unsigned atoms_r = 64'(hstmc_pkg::ATOM_COUNT_RST);
  longint unsigned box_r = 64'(hstmc_pkg::BOX_LENGTH_RST);
  longint unsigned inv_r = 64'(hstmc_pkg::INV_BOX_RST);
  longint unsigned contact_r = 64'(hstmc_pkg::CONTACT_SQ_RST);
  longint unsigned dia = 64'(UNIT);

  int stored_x [SLOTS];
  int stored_y [SLOTS];
  int stored_z [SLOTS];
  bit loaded [SLOTS];

  answer_t     answers_due [$];
  script_row_t script [$];

  int errors = 0;
  int n_loads = 0;
  int n_trials = 0;
  int n_rejects = 0;
  int n_writes = 0;
  int beats_sent = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  hard_sphere_trial_move_check #(.ATOM_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_atom_index(in_atom_index),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_accepted(out_accepted),
    .out_echo_index(out_echo_index)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Squared minimum-image distance along one axis in Q32.32, all ones when the wrap fails.
  function automatic longint unsigned axis_sq_dist(longint d);
    bit              neg;
    longint unsigned mag;
    longint unsigned n;
    longint unsigned wm;
    longint          term;
    longint          w;
    neg = d < 0;
    mag = neg ? -d : d;
    n = (mag * inv_r + 64'h8000_0000) >> 32;
    term = n * box_r;
    w = neg ? d + term : d - term;
    wm = (w < 0) ? -w : w;
    if (wm >= 64'h1_0000_0000) return '1;
    return wm * wm;
  endfunction

  function automatic logic predict_move(logic kind, logic [9:0] idx, int px, int py, int pz);
    int         lim;
    logic       ok;
    logic [65:0] total;
    ok = 1'b1;
    if (kind == hstmc_pkg::KIND_TRIAL) begin
      lim = (atoms_r < SLOTS) ? int'(atoms_r) : SLOTS;
      for (int i = 0; i < lim && ok; i++) begin
        if (i != idx) begin
          total = 66'(axis_sq_dist(longint'(stored_x[i]) - px))
                + 66'(axis_sq_dist(longint'(stored_y[i]) - py))
                + 66'(axis_sq_dist(longint'(stored_z[i]) - pz));
          if (total < 66'(contact_r)) ok = 1'b0;
        end
      end
    end
    if (ok) begin
      stored_x[idx] = px;
      stored_y[idx] = py;
      stored_z[idx] = pz;
      loaded[idx] = 1'b1;
    end
    return ok;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 6) == 0) return int'($urandom());
    return int'($urandom_range(0, 32'(2 * box_r)) - 32'(box_r));
  endfunction

  function automatic int jitter(int c);
    return c + int'($urandom_range(0, 32'(2 * dia))) - int'(dia);
  endfunction

  function automatic void add_cfg(logic [1:0] which, longint unsigned value);
    script_row_t row;
    row.what = ROW_CFG;
    row.which = which;
    row.value = value;
    script.push_back(row);
  endfunction

  function automatic void add_beat(logic kind, logic [9:0] idx, int px, int py, int pz,
                                   bit typed = 1'b0, bit want = 1'b0);
    script_row_t row;
    row.what = ROW_BEAT;
    row.kind = kind;
    row.idx = idx;
    row.px = px;
    row.py = py;
    row.pz = pz;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  task automatic write_reg(logic [1:0] which, longint unsigned value);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value[62:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (which)
      hstmc_pkg::CFG_ATOM_COUNT: atoms_r = value & 64'h7FF;
      hstmc_pkg::CFG_BOX_LENGTH: box_r = value & 64'h7FFF_FFFF;
      hstmc_pkg::CFG_INV_BOX:    inv_r = value & 64'hFFFF_FFFF;
      hstmc_pkg::CFG_CONTACT_SQ: contact_r = value & 64'h7FFF_FFFF_FFFF_FFFF;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_beat(logic kind, logic [9:0] idx, int px, int py, int pz,
                           bit typed = 1'b0, bit want = 1'b0);
    answer_t due;
    int      gap;
    due.accepted = predict_move(kind, idx, px, py, pz);
    if (kind == hstmc_pkg::KIND_TRIAL) begin
      n_trials++;
      if (!due.accepted) n_rejects++;
    end else begin
      n_loads++;
    end
    if (typed) due.accepted = want;
    due.echo = idx;
    answers_due.push_back(due);
    beats_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_atom_index <= idx;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic new_setting(bit sane);
    longint unsigned box;
    longint unsigned inv;
    int              roll;
    roll = $urandom_range(0, 19);
    if (!sane && roll == 0) box = 1;
    else if (!sane && roll == 1) box = 64'h7FFF_FFFF;
    else box = $urandom_range(UNIT, 2000 * UNIT);
    inv = 64'h1_0000_0000 / box;
    if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
    roll = $urandom_range(0, 19);
    if (!sane && roll == 0) inv = 0;
    else if (!sane && roll < 3) inv = $urandom();
    dia = box / $urandom_range(sane ? 16 : 2, 32);
    write_reg(hstmc_pkg::CFG_BOX_LENGTH, box);
    write_reg(hstmc_pkg::CFG_INV_BOX, inv);
    roll = $urandom_range(0, 19);
    if (!sane && roll == 0) write_reg(hstmc_pkg::CFG_CONTACT_SQ, 0);
    else if (!sane && roll == 1) write_reg(hstmc_pkg::CFG_CONTACT_SQ, 64'h7FFF_FFFF_FFFF_FFFF);
    else if (!sane && roll == 2) write_reg(hstmc_pkg::CFG_CONTACT_SQ, {$urandom(), $urandom()});
    else write_reg(hstmc_pkg::CFG_CONTACT_SQ, dia * dia);
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin
    if (stall_left == 0) stall_left = pick_gap();
    out_ready <= (stall_left == 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin : check_answers
    answer_t due;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: beat with no answer pending: accepted %0b, atom %0d", $time,
                 out_accepted, out_echo_index);
        errors++;
      end else begin
        due = answers_due.pop_front();
        if (out_accepted !== due.accepted) begin
          $display("%0t: accepted for atom %0d: expected %0b, got %0b", $time, due.echo,
                   due.accepted, out_accepted);
          errors++;
        end
        if (out_echo_index !== due.echo) begin
          $display("%0t: echo_index: expected %0d, got %0d", $time, due.echo,
                   out_echo_index);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int         start;
    int         count;
    int         roll;
    int         j;
    logic [9:0] idx;

    // With the reset settings every neighbor wraps to within contact of the trial.
    add_beat(hstmc_pkg::KIND_TRIAL, 0, 0, 0, 0, 1'b1, 1'b1);
    add_beat(hstmc_pkg::KIND_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1, 1'b1);
    add_beat(hstmc_pkg::KIND_LOAD, 1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             1'b1, 1'b1);
    add_beat(hstmc_pkg::KIND_LOAD, 1, UNIT / 2, -UNIT / 2, 0, 1'b1, 1'b1);
    add_cfg(hstmc_pkg::CFG_ATOM_COUNT, 2);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, 0, 0, 0, 1'b1, 1'b0);
    add_cfg(hstmc_pkg::CFG_CONTACT_SQ, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, 1, 2, 3, 1'b1, 1'b1);
    add_cfg(hstmc_pkg::CFG_CONTACT_SQ, 64'h7FFF_FFFF_FFFF_FFFF);
    add_beat(hstmc_pkg::KIND_TRIAL, 0, 0, 0, 0, 1'b1, 1'b0);
    // An inconsistent box pair makes the wrapped value too wide, so the pair never touches.
    add_cfg(hstmc_pkg::CFG_BOX_LENGTH, 64'h7FFF_FFFF);
    add_cfg(hstmc_pkg::CFG_INV_BOX, 64'hFFFF_FFFF);
    add_beat(hstmc_pkg::KIND_LOAD, 1, 32'h8000_0000, 0, 0, 1'b1, 1'b1);
    add_beat(hstmc_pkg::KIND_TRIAL, 0, 32'h7FFF_FFFF, 0, 0);
    add_cfg(hstmc_pkg::CFG_INV_BOX, 0);
    add_cfg(hstmc_pkg::CFG_CONTACT_SQ, 64'h1_0000_0000);
    add_beat(hstmc_pkg::KIND_LOAD, 0, 0, 0, 0, 1'b1, 1'b1);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, UNIT - 1, 0, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, UNIT, 0, 0);
    add_cfg(hstmc_pkg::CFG_BOX_LENGTH, 100 * UNIT);
    add_cfg(hstmc_pkg::CFG_INV_BOX, 655);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, 6520832, 0, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 1, 50 * UNIT, 0, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 0, 0, 0, 0);
    add_cfg(hstmc_pkg::CFG_ATOM_COUNT, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 5, 1, 1, 1, 1'b1, 1'b1);
    add_cfg(hstmc_pkg::CFG_ATOM_COUNT, 2);
    add_beat(hstmc_pkg::KIND_TRIAL, 700, UNIT / 4, 0, 0);
    add_beat(hstmc_pkg::KIND_TRIAL, 700, 20 * UNIT, 20 * UNIT, 20 * UNIT);
    add_beat(hstmc_pkg::KIND_LOAD, 512, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h0F0F_0F0F,
             1'b1, 1'b1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].what == ROW_CFG) begin
        write_reg(script[r].which, script[r].value);
      end else begin
        send_beat(script[r].kind, script[r].idx, script[r].px, script[r].py, script[r].pz,
                  script[r].typed, script[r].want);
      end
    end

    start = beats_sent;
    while (beats_sent < start + RANDOM_BEATS) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) count = 0;
      else if (roll == 1) count = 1;
      else if (roll < 4) count = $urandom_range(25, 160);
      else count = $urandom_range(2, 24);
      new_setting(1'b0);
      write_reg(hstmc_pkg::CFG_ATOM_COUNT, 64'(count));
      for (int i = 0; i < count; i++) begin
        if (!loaded[i]) begin
          send_beat(hstmc_pkg::KIND_LOAD, 10'(i), rand_coord(), rand_coord(), rand_coord());
        end
      end
      repeat ($urandom_range(8, 30)) begin
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
          send_beat(hstmc_pkg::KIND_LOAD, 10'($urandom_range(0, SLOTS - 1)), rand_coord(),
                    rand_coord(), rand_coord());
        end else begin
          idx = (count != 0 && roll < 8) ? 10'($urandom_range(0, count - 1))
                                         : 10'($urandom_range(0, SLOTS - 1));
          if (count != 0 && roll < 6) begin
            j = $urandom_range(0, count - 1);
            send_beat(hstmc_pkg::KIND_TRIAL, idx, jitter(stored_x[j]), jitter(stored_y[j]),
                      jitter(stored_z[j]));
          end else begin
            send_beat(hstmc_pkg::KIND_TRIAL, idx, rand_coord(), rand_coord(), rand_coord());
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d loads and %0d trial moves, %0d of them rejected,", n_loads,
             n_trials, n_rejects);
    $display("across %0d register writes with random box, contact and count settings.",
             n_writes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
